// ===== hw/rtl/bfc_pkg.sv =====
package bfc_pkg;

    localparam int POS_W           = 9;
    localparam int LEN_W           = 9;
    localparam int BYTE_W          = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 9;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int MIN_FRAME_LEN   = 8;
    localparam int CKS_MIN_LEN     = 4;

    localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BODY_START  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ACK_CLASS   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ACK_ID      = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ACK_LEN_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_ACK_LEN_HI  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ACKED_CLASS = POS_W'(6);
    localparam logic [POS_W-1:0] POS_ACKED_ID    = POS_W'(7);

    localparam logic [BYTE_W-1:0] ACK_LEN_LOW  = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] ACK_LEN_HIGH = BYTE_W'(0);

    // reset values of the registers
    localparam logic [LEN_W-1:0]  RST_EXPECTED_LEN = LEN_W'(100);
    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST   = BYTE_W'(181);
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND  = BYTE_W'(98);
    localparam logic              RST_CHECK_ACK    = 1'b0;
    localparam logic [BYTE_W-1:0] RST_ACK_CLASS    = BYTE_W'(5);
    localparam logic [BYTE_W-1:0] RST_ACK_ID       = BYTE_W'(1);
    localparam logic [BYTE_W-1:0] RST_ACKED_CLASS  = BYTE_W'(6);
    localparam logic [BYTE_W-1:0] RST_ACKED_ID     = BYTE_W'(8);

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_LENGTH   = 3'd1,
        STATUS_SYNC     = 3'd2,
        STATUS_CHECKSUM = 3'd3,
        STATUS_ACK      = 3'd4
    } frame_status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_LEN = 3'd0,
        CFG_SYNC_FIRST   = 3'd1,
        CFG_SYNC_SECOND  = 3'd2,
        CFG_CHECK_ACK    = 3'd3,
        CFG_ACK_CLASS    = 3'd4,
        CFG_ACK_ID       = 3'd5,
        CFG_ACKED_CLASS  = 3'd6,
        CFG_ACKED_ID     = 3'd7
    } cfg_index_t;

endpackage

// ===== hw/rtl/binary_frame_checker_unit.sv =====
// Binary frame checker. Feed the bytes of one received burst, one item per
// cycle, with burst_end set on the last byte. The block checks the two sync
// bytes, runs an 8-bit Fletcher sum over bytes 2 to length-3 and compares it
// with the two trailing bytes, and, with check_ack set, checks acknowledge
// content in bytes 2 to 7. For each burst it returns one item on frame_status
// (0 ok, 1 length mismatch, 2 bad sync, 3 bad checksum, 4 ack mismatch; the
// first fault in that order wins). Throughput is one byte per cycle unless a
// last byte waits for a stalled status to leave. The last byte passes through
// a single register stage, the input register, whose add-and-compare is
// finished before the result register, and its status is then loaded into
// the result register. The result register lets the next burst's bytes
// enter while a status is still stalled. Write the
// configuration registers only while the block is idle; cfg_ready is always
// high.
module binary_frame_checker_unit
    import bfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   burst_end,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             frame_status,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  expected_len_reg;
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic              check_ack_reg;
    logic [BYTE_W-1:0] ack_class_reg;
    logic [BYTE_W-1:0] ack_id_reg;
    logic [BYTE_W-1:0] acked_class_reg;
    logic [BYTE_W-1:0] acked_id_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_len_reg <= RST_EXPECTED_LEN;
            sync_first_reg   <= RST_SYNC_FIRST;
            sync_second_reg  <= RST_SYNC_SECOND;
            check_ack_reg    <= RST_CHECK_ACK;
            ack_class_reg    <= RST_ACK_CLASS;
            ack_id_reg       <= RST_ACK_ID;
            acked_class_reg  <= RST_ACKED_CLASS;
            acked_id_reg     <= RST_ACKED_ID;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_EXPECTED_LEN: expected_len_reg <= cfg_data[LEN_W-1:0];
                CFG_SYNC_FIRST:   sync_first_reg   <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND:  sync_second_reg  <= cfg_data[BYTE_W-1:0];
                CFG_CHECK_ACK:    check_ack_reg    <= cfg_data[0];
                CFG_ACK_CLASS:    ack_class_reg    <= cfg_data[BYTE_W-1:0];
                CFG_ACK_ID:       ack_id_reg       <= cfg_data[BYTE_W-1:0];
                CFG_ACKED_CLASS:  acked_class_reg  <= cfg_data[BYTE_W-1:0];
                CFG_ACKED_ID:     acked_id_reg     <= cfg_data[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: one byte waits here for its checks
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_end_reg;
    logic              s1_go;
    logic              in_take;

    // A byte that ends a burst needs room in the result register; any other
    // byte only updates the running state and always moves on.
    assign s1_go    = s1_valid_reg && (!s1_end_reg || !out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
            s1_end_reg  <= burst_end;
        end
    end

    // ------------------------------------------------------------------
    // Burst state and per-byte checks
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_a_reg;
    logic [BYTE_W-1:0] sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg;
    logic [BYTE_W-1:0] sum_b_next;
    logic              sync_fault_reg;
    logic              sync_fault_next;
    logic              cks_fault_reg;
    logic              cks_fault_next;
    logic              ack_fault_reg;
    logic              ack_fault_next;

    logic              pos_live;
    logic [POS_W:0]    pos_p1;
    logic [POS_W:0]    pos_p2;
    logic [POS_W:0]    len_ext;
    logic              cks_on;
    logic              in_body;
    logic              at_sum_a;
    logic              at_sum_b;
    logic [BYTE_W-1:0] sum_a_add;
    logic [BYTE_W-1:0] sum_b_add;
    logic              sync_hit;
    logic              cks_hit;
    logic              ack_hit;
    logic              sync_now;
    logic              cks_now;
    logic              ack_now;
    logic              len_ok;
    frame_status_t     status_now;

    assign pos_live  = (pos_reg != POS_SAT);
    assign pos_p1    = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign pos_p2    = {1'b0, pos_reg} + (POS_W+1)'(2);
    assign len_ext   = {1'b0, expected_len_reg};
    assign cks_on    = (len_ext >= (POS_W+1)'(CKS_MIN_LEN));
    assign in_body   = (pos_reg >= POS_BODY_START) && (pos_p2 < len_ext);
    assign at_sum_a  = (pos_p2 == len_ext);
    assign at_sum_b  = (pos_p1 == len_ext);

    assign sum_a_add = sum_a_reg + s1_byte_reg;
    assign sum_b_add = sum_b_reg + sum_a_add;

    always_comb
    begin
        sync_hit = ((pos_reg == POS_SYNC_FIRST)  && (s1_byte_reg != sync_first_reg))
                || ((pos_reg == POS_SYNC_SECOND) && (s1_byte_reg != sync_second_reg));

        cks_hit = 1'b0;
        if (cks_on && !in_body)
        begin
            if (at_sum_a)
            begin
                cks_hit = (s1_byte_reg != sum_a_reg);
            end
            else if (at_sum_b)
            begin
                cks_hit = (s1_byte_reg != sum_b_reg);
            end
        end

        ack_hit = check_ack_reg && (
                   ((pos_reg == POS_ACK_CLASS)   && (s1_byte_reg != ack_class_reg))
                || ((pos_reg == POS_ACK_ID)      && (s1_byte_reg != ack_id_reg))
                || ((pos_reg == POS_ACK_LEN_LO)  && (s1_byte_reg != ACK_LEN_LOW))
                || ((pos_reg == POS_ACK_LEN_HI)  && (s1_byte_reg != ACK_LEN_HIGH))
                || ((pos_reg == POS_ACKED_CLASS) && (s1_byte_reg != acked_class_reg))
                || ((pos_reg == POS_ACKED_ID)    && (s1_byte_reg != acked_id_reg)));
    end

    // fault flags including this byte; a saturated count judges nothing
    assign sync_now = sync_fault_reg || (pos_live && sync_hit);
    assign cks_now  = cks_fault_reg  || (pos_live && cks_hit);
    assign ack_now  = ack_fault_reg  || (pos_live && ack_hit);

    assign len_ok = pos_live && at_sum_b
                 && (len_ext >= (POS_W+1)'(MIN_FRAME_LEN))
                 && (len_ext <= (POS_W+1)'(MAX_FRAME_BYTES));

    always_comb
    begin
        priority if (!len_ok)
        begin
            status_now = STATUS_LENGTH;
        end
        else if (sync_now)
        begin
            status_now = STATUS_SYNC;
        end
        else if (cks_now)
        begin
            status_now = STATUS_CHECKSUM;
        end
        else if (ack_now)
        begin
            status_now = STATUS_ACK;
        end
        else
        begin
            status_now = STATUS_OK;
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        sync_fault_next = sync_fault_reg;
        cks_fault_next  = cks_fault_reg;
        ack_fault_next  = ack_fault_reg;
        if (s1_go)
        begin
            if (s1_end_reg)
            begin
                // clear for the next burst
                pos_next        = '0;
                sum_a_next      = '0;
                sum_b_next      = '0;
                sync_fault_next = 1'b0;
                cks_fault_next  = 1'b0;
                ack_fault_next  = 1'b0;
            end
            else
            begin
                sync_fault_next = sync_now;
                cks_fault_next  = cks_now;
                ack_fault_next  = ack_now;
                if (pos_live)
                begin
                    pos_next = pos_p1[POS_W-1:0];
                    if (cks_on && in_body)
                    begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            sync_fault_reg <= 1'b0;
            cks_fault_reg  <= 1'b0;
            ack_fault_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            sync_fault_reg <= sync_fault_next;
            cks_fault_reg  <= cks_fault_next;
            ack_fault_reg  <= ack_fault_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_load;
    frame_status_t status_reg;

    assign out_load = s1_go && s1_end_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;

endmodule

// ===== hw/rtl/bfc_checker.sv =====
module bfc_checker
    import bfc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   burst_end,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [2:0]             frame_status
);

    // stalled status holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_status))
        else $error("stalled status changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_status <= STATUS_ACK)
        else $error("status code out of range");

    // input backs up only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result side free");

    // a fresh status follows a taken last byte, with only the input register between them
    a_status_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && burst_end, 2))
        else $error("status without a last byte");

endmodule

bind binary_frame_checker_unit bfc_checker u_bfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .burst_end    (burst_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status)
);
